### src/mlpq_pkg.sv
// package for the multilevel priority fifo
// holds field widths, parameter defaults and the control state type; no dependencies

package mlpq_pkg;

    // parameter defaults
    localparam int DEF_NUM_LEVELS  = 10;
    localparam int DEF_LEVEL_DEPTH = 16;
    localparam int DEF_MAX_POP     = 16;
    localparam int DEF_TAG_BITS    = 16;

    // fixed field widths of the stream payloads
    localparam int TAG_FIELD_W = 16;
    localparam int LVL_FIELD_W = 4;
    localparam int CNT_FIELD_W = 5;
    localparam int TOT_FIELD_W = 8;

    // stream bus widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // request kinds carried in tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_WR,
        ST_POP_PICK,
        ST_POP_META,
        ST_POP_DATA
    } t_state;

endpackage

### src/mlpq_ram.sv
// generic simple dual port ram, one write and one registered read port
// depends on nothing

module mlpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/mlpq_lowest.sv
// finds the lowest-numbered set bit of the level occupancy vector
// depends on nothing

module mlpq_lowest #(
    parameter int N  = 10,
    parameter int IW = $clog2(N)
) (
    input  logic [N-1:0]  i_vec,
    output logic          o_found,
    output logic [IW-1:0] o_idx
);

    // priority encode, lowest index wins
    always_comb begin
        o_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_idx = IW'(i);
            end
        end
    end

    assign o_found = |i_vec;

endmodule

### src/multilevel_priority_fifo.sv
// multilevel priority fifo: one tag fifo per level, tags in a ram, per-level pointers in a ram
// only idle takes a request; insert: pointer read in idle, tag and pointer write in ST_INS_WR
// pop: per item, meta read in ST_POP_PICK, meta write with tag read in ST_POP_META, tag data
//   in ST_POP_DATA; a pop that removes nothing answers from ST_POP_PICK
// reset (i_rst_n low, synchronous) empties all levels at once via per-level valid bits
// depends on mlpq_pkg, mlpq_ram, mlpq_lowest

module multilevel_priority_fifo
    import mlpq_pkg::*;
#(
    parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    parameter int MAX_POP     = DEF_MAX_POP,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [15:0] item_tag, [19:16] item_level, [24:20] pop_count, rest zero
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // [0] req_type
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [15:0] out_tag, [19:16] out_level, [27:20] total_count, rest zero
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // [0] accepted, [1] item_valid
    output logic [M_TUSER_W-1:0] o_m_axis_tuser,
    output logic                 o_m_axis_tlast
);

    localparam int LW    = $clog2(NUM_LEVELS);
    localparam int PW    = $clog2(LEVEL_DEPTH);
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int SLOTS = NUM_LEVELS * LEVEL_DEPTH;
    localparam int SAW   = $clog2(SLOTS);
    localparam int TOT_W = $clog2(SLOTS + 1);
    localparam int WW    = $clog2(MAX_POP + 1);
    localparam int SW    = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
    localparam int PAD_W = M_TDATA_W - TOT_FIELD_W - LVL_FIELD_W - TAG_FIELD_W;

    typedef struct packed {
        logic [PW-1:0] head;
        logic [PW-1:0] tail;
        logic [CW-1:0] count;
    } t_meta;

    localparam int MW = $bits(t_meta);

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        ptr_next = (p == PW'(LEVEL_DEPTH - 1)) ? '0 : PW'(p + PW'(1));
    endfunction

    // input field unpacking
    logic                   in_req;
    logic [TAG_FIELD_W-1:0] in_tag;
    logic [LVL_FIELD_W-1:0] in_lvl;
    logic [CNT_FIELD_W-1:0] in_cnt;
    logic                   in_lvl_ok;

    assign in_req    = i_s_axis_tuser[0];
    assign in_tag    = i_s_axis_tdata[15:0];
    assign in_lvl    = i_s_axis_tdata[19:16];
    assign in_cnt    = i_s_axis_tdata[24:20];
    assign in_lvl_ok = (in_lvl != '0) && (int'(in_lvl) <= NUM_LEVELS);

    // control and payload registers
    t_state                 r_state, n_state;
    logic [SW-1:0]          r_req_tag, n_req_tag;
    logic                   r_lvl_ok, n_lvl_ok;
    logic [LW-1:0]          r_lvl_idx, n_lvl_idx;
    logic [WW-1:0]          r_want, n_want;
    logic [WW-1:0]          r_n, n_n;
    logic [LW-1:0]          r_q, n_q;
    logic                   r_last, n_last;
    logic [TOT_W-1:0]       r_total, n_total;
    logic [NUM_LEVELS-1:0]  r_nonempty, n_nonempty;
    logic [NUM_LEVELS-1:0]  r_meta_vld, n_meta_vld;
    logic                   r_meta_rd_vld;

    // output register
    logic                   r_m_tvalid, n_m_tvalid;
    logic                   r_o_acc, n_o_acc;
    logic                   r_o_vld, n_o_vld;
    logic [TAG_FIELD_W-1:0] r_o_tag, n_o_tag;
    logic [LVL_FIELD_W-1:0] r_o_lvl, n_o_lvl;
    logic [TOT_FIELD_W-1:0] r_o_tot, n_o_tot;
    logic                   r_o_last, n_o_last;
    logic                   out_free;

    // memory ports
    logic          meta_wr_en, meta_rd_en;
    logic [LW-1:0] meta_wr_addr, meta_rd_addr;
    t_meta         meta_wr_data;
    logic [MW-1:0] meta_rd_data;
    t_meta         meta_cur;
    logic          slot_wr_en, slot_rd_en;
    logic [SAW-1:0] slot_wr_addr, slot_rd_addr;
    logic [SW-1:0] slot_rd_data;

    logic          sel_found;
    logic [LW-1:0] sel_idx;

    assign out_free = !r_m_tvalid || i_m_axis_tready;
    assign meta_cur = r_meta_rd_vld ? t_meta'(meta_rd_data) : '0;

    // tag storage, all levels side by side
    mlpq_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (slot_wr_en),
        .i_wr_addr (slot_wr_addr),
        .i_wr_data (r_req_tag),
        .i_rd_en   (slot_rd_en),
        .i_rd_addr (slot_rd_addr),
        .o_rd_data (slot_rd_data)
    );

    // per-level head, tail and count
    mlpq_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_LEVELS)
    ) u_meta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (meta_wr_en),
        .i_wr_addr (meta_wr_addr),
        .i_wr_data (meta_wr_data),
        .i_rd_en   (meta_rd_en),
        .i_rd_addr (meta_rd_addr),
        .o_rd_data (meta_rd_data)
    );

    // most urgent non-empty level
    mlpq_lowest #(
        .N  (NUM_LEVELS),
        .IW (LW)
    ) u_lowest (
        .i_vec   (r_nonempty),
        .o_found (sel_found),
        .o_idx   (sel_idx)
    );

    // next state, memory control and result formation
    always_comb begin
        n_state      = r_state;
        n_req_tag    = r_req_tag;
        n_lvl_ok     = r_lvl_ok;
        n_lvl_idx    = r_lvl_idx;
        n_want       = r_want;
        n_n          = r_n;
        n_q          = r_q;
        n_last       = r_last;
        n_total      = r_total;
        n_nonempty   = r_nonempty;
        n_meta_vld   = r_meta_vld;
        n_m_tvalid   = r_m_tvalid && !i_m_axis_tready;
        n_o_acc      = r_o_acc;
        n_o_vld      = r_o_vld;
        n_o_tag      = r_o_tag;
        n_o_lvl      = r_o_lvl;
        n_o_tot      = r_o_tot;
        n_o_last     = r_o_last;
        meta_wr_en   = 1'b0;
        meta_wr_addr = r_q;
        meta_wr_data = meta_cur;
        meta_rd_en   = 1'b0;
        meta_rd_addr = sel_idx;
        slot_wr_en   = 1'b0;
        slot_wr_addr = SAW'(r_lvl_idx) * SAW'(LEVEL_DEPTH) + SAW'(meta_cur.tail);
        slot_rd_en   = 1'b0;
        slot_rd_addr = SAW'(r_q) * SAW'(LEVEL_DEPTH) + SAW'(meta_cur.head);
        o_s_axis_tready = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (in_req == REQ_INSERT) begin
                        // only a legal level touches the pointer memory
                        meta_rd_en   = in_lvl_ok;
                        meta_rd_addr = LW'(in_lvl - LVL_FIELD_W'(1));
                        n_req_tag    = SW'(in_tag);
                        n_lvl_ok     = in_lvl_ok;
                        n_lvl_idx    = LW'(in_lvl - LVL_FIELD_W'(1));
                        n_state      = ST_INS_WR;
                    end else begin
                        n_want  = (int'(in_cnt) > MAX_POP) ? WW'(MAX_POP) : WW'(in_cnt);
                        n_n     = '0;
                        n_state = ST_POP_PICK;
                    end
                end
            end

            // append the tag when the level is legal and not full
            ST_INS_WR: begin
                if (out_free) begin
                    n_o_acc = 1'b0;
                    if (r_lvl_ok && (meta_cur.count < CW'(LEVEL_DEPTH))) begin
                        slot_wr_en              = 1'b1;
                        meta_wr_en              = 1'b1;
                        meta_wr_addr            = r_lvl_idx;
                        meta_wr_data.tail       = ptr_next(meta_cur.tail);
                        meta_wr_data.count      = CW'(meta_cur.count + CW'(1));
                        n_meta_vld[r_lvl_idx]   = 1'b1;
                        n_nonempty[r_lvl_idx]   = 1'b1;
                        n_total                 = TOT_W'(r_total + TOT_W'(1));
                        n_o_acc                 = 1'b1;
                    end
                    n_m_tvalid = 1'b1;
                    n_o_vld    = 1'b0;
                    n_o_tag    = '0;
                    n_o_lvl    = '0;
                    n_o_tot    = TOT_FIELD_W'(n_total);
                    n_o_last   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end

            // pick the level or answer an empty pop
            ST_POP_PICK: begin
                if ((r_want == '0) || !sel_found) begin
                    if (out_free) begin
                        n_m_tvalid = 1'b1;
                        n_o_acc    = 1'b0;
                        n_o_vld    = 1'b0;
                        n_o_tag    = '0;
                        n_o_lvl    = '0;
                        n_o_tot    = TOT_FIELD_W'(r_total);
                        n_o_last   = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    meta_rd_en   = 1'b1;
                    meta_rd_addr = sel_idx;
                    n_q          = sel_idx;
                    n_state      = ST_POP_META;
                end
            end

            // read the head tag and retire it from the level
            ST_POP_META: begin
                slot_rd_en         = 1'b1;
                meta_wr_en         = 1'b1;
                meta_wr_addr       = r_q;
                meta_wr_data.head  = ptr_next(meta_cur.head);
                meta_wr_data.count = CW'(meta_cur.count - CW'(1));
                n_meta_vld[r_q]    = 1'b1;
                if (meta_cur.count == CW'(1)) begin
                    n_nonempty[r_q] = 1'b0;
                end
                n_total = TOT_W'(r_total - TOT_W'(1));
                n_n     = WW'(r_n + WW'(1));
                n_last  = (n_n == r_want) || (n_nonempty == '0);
                n_state = ST_POP_DATA;
            end

            // hand the removed item to the output register
            ST_POP_DATA: begin
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    n_o_acc    = 1'b1;
                    n_o_vld    = 1'b1;
                    n_o_tag    = TAG_FIELD_W'(slot_rd_data);
                    n_o_lvl    = LVL_FIELD_W'({1'b0, r_q} + (LW + 1)'(1));
                    n_o_tot    = TOT_FIELD_W'(r_total);
                    n_o_last   = r_last;
                    n_state    = r_last ? ST_IDLE : ST_POP_PICK;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_total       <= '0;
            r_nonempty    <= '0;
            r_meta_vld    <= '0;
            r_meta_rd_vld <= 1'b0;
            r_m_tvalid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_total    <= n_total;
            r_nonempty <= n_nonempty;
            r_meta_vld <= n_meta_vld;
            r_m_tvalid <= n_m_tvalid;
            if (meta_rd_en) begin
                r_meta_rd_vld <= r_meta_vld[meta_rd_addr];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req_tag <= n_req_tag;
        r_lvl_ok  <= n_lvl_ok;
        r_lvl_idx <= n_lvl_idx;
        r_want    <= n_want;
        r_n       <= n_n;
        r_q       <= n_q;
        r_last    <= n_last;
        r_o_acc   <= n_o_acc;
        r_o_vld   <= n_o_vld;
        r_o_tag   <= n_o_tag;
        r_o_lvl   <= n_o_lvl;
        r_o_tot   <= n_o_tot;
        r_o_last  <= n_o_last;
    end

    // result bus packing
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_o_tot, r_o_lvl, r_o_tag};
    assign o_m_axis_tuser  = {r_o_vld, r_o_acc};
    assign o_m_axis_tlast  = r_o_last;

    // an empty queue and an empty level map go together
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total == '0) == (r_nonempty == '0))
        else $error("occupancy total and level map disagree");

    // occupancy never exceeds the total storage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOT_W'(SLOTS))
        else $error("occupancy above capacity");

    // each retire step removes exactly one item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP_META) |=> (r_total == TOT_W'($past(r_total) - TOT_W'(1))))
        else $error("pop did not remove exactly one item");

    // a removed item is always flagged accepted and carries a nonzero level
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && r_o_vld) |-> (r_o_acc && (r_o_lvl != '0)))
        else $error("removed item without level or accept");

endmodule

### tb/multilevel_priority_fifo_tb.sv
// self-checking testbench for multilevel_priority_fifo: random and directed requests on the
// input stream, per-level fifo predictor, field-by-field check of every output transaction
// depends on mlpq_pkg and the multilevel_priority_fifo rtl

module multilevel_priority_fifo_tb;
    import mlpq_pkg::*;

    localparam int NUM_LEVELS  = DEF_NUM_LEVELS;
    localparam int LEVEL_DEPTH = DEF_LEVEL_DEPTH;
    localparam int MAX_POP     = DEF_MAX_POP;
    localparam int RAND_ITEMS  = 255;
    localparam int CALM_ITEMS  = 40;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 30;

    // one request as offered on the input stream
    typedef struct packed {
        logic                   req;
        logic [TAG_FIELD_W-1:0] tag;
        logic [LVL_FIELD_W-1:0] lvl;
        logic [CNT_FIELD_W-1:0] cnt;
        logic                   drain;
    } pq_req_t;

    // one result as seen on the output stream
    typedef struct packed {
        logic                   accepted;
        logic                   item_valid;
        logic [TAG_FIELD_W-1:0] tag;
        logic [LVL_FIELD_W-1:0] lvl;
        logic [TOT_FIELD_W-1:0] total;
        logic                   last;
    } pq_resp_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] i_s_axis_tuser = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [M_TUSER_W-1:0] o_m_axis_tuser;
    logic                 o_m_axis_tlast;

    pq_req_t  pending_reqs[$];
    pq_resp_t expected_results[$];
    pq_req_t  offered_req;

    int offered_items  = 0;
    int accepted_items = 0;
    int total_items    = 0;
    int calm_from      = 1000000;
    int err_count      = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit drain_next     = 1'b0;

    // predictor state: per-level ring of tags with pointers and counts
    logic [TAG_FIELD_W-1:0] mdl_slots[NUM_LEVELS][LEVEL_DEPTH];
    int mdl_head[NUM_LEVELS];
    int mdl_tail[NUM_LEVELS];
    int mdl_count[NUM_LEVELS];
    int mdl_total = 0;

    multilevel_priority_fifo u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        // [15:0] item_tag, [19:16] item_level, [24:20] pop_count, rest zero
        .i_s_axis_tdata  (i_s_axis_tdata),
        // [0] req_type
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        // [15:0] out_tag, [19:16] out_level, [27:20] total_count, rest zero
        .o_m_axis_tdata  (o_m_axis_tdata),
        // [0] accepted, [1] item_valid
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // expected results of one accepted request, state updated as the block does
    task automatic predict_request(input pq_req_t rq);
        int li;
        int k;
        int want_n;
        int take_n;
        pq_resp_t r;
        r = '0;
        if (rq.req == REQ_INSERT) begin
            r.last = 1'b1;
            if (rq.lvl >= 1 && rq.lvl <= NUM_LEVELS) begin
                li = int'(rq.lvl) - 1;
                if (mdl_count[li] < LEVEL_DEPTH) begin
                    mdl_slots[li][mdl_tail[li]] = rq.tag;
                    mdl_tail[li] = (mdl_tail[li] + 1) % LEVEL_DEPTH;
                    mdl_count[li]++;
                    mdl_total++;
                    r.accepted = 1'b1;
                end
            end
            r.total = TOT_FIELD_W'(mdl_total);
            expected_results.push_back(r);
        end else begin
            // oversized counts saturate, an empty queue or a zero count gives one reject
            want_n = (int'(rq.cnt) > MAX_POP) ? MAX_POP : int'(rq.cnt);
            take_n = (want_n < mdl_total) ? want_n : mdl_total;
            if (take_n == 0) begin
                r.last  = 1'b1;
                r.total = TOT_FIELD_W'(mdl_total);
                expected_results.push_back(r);
            end
            for (k = 0; k < take_n; k++) begin
                li = 0;
                while (mdl_count[li] == 0) li++;
                r.accepted   = 1'b1;
                r.item_valid = 1'b1;
                r.tag        = mdl_slots[li][mdl_head[li]];
                r.lvl        = LVL_FIELD_W'(li + 1);
                mdl_head[li] = (mdl_head[li] + 1) % LEVEL_DEPTH;
                mdl_count[li]--;
                mdl_total--;
                r.total      = TOT_FIELD_W'(mdl_total);
                r.last       = (k == take_n - 1);
                expected_results.push_back(r);
            end
        end
    endtask

    task automatic compare_field(input string fname, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            if (err_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, got_v);
            err_count++;
        end
    endtask

    task automatic add_req(input logic req, input int tag, input int lvl, input int cnt);
        pq_req_t rq;
        rq.req   = req;
        rq.tag   = TAG_FIELD_W'(tag);
        rq.lvl   = LVL_FIELD_W'(lvl);
        rq.cnt   = CNT_FIELD_W'(cnt);
        rq.drain = drain_next;
        drain_next = 1'b0;
        pending_reqs.push_back(rq);
    endtask

    // monitor: check output transactions, then feed accepted input transactions to the predictor
    always @(posedge i_clk) begin : monitor_proc
        pq_resp_t got;
        pq_resp_t want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.accepted   = o_m_axis_tuser[0];
                got.item_valid = o_m_axis_tuser[1];
                got.tag        = o_m_axis_tdata[15:0];
                got.lvl        = o_m_axis_tdata[19:16];
                got.total      = o_m_axis_tdata[27:20];
                got.last       = o_m_axis_tlast;
                if (expected_results.size() == 0) begin
                    if (err_count < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("accepted", want.accepted, got.accepted);
                    compare_field("item_valid", want.item_valid, got.item_valid);
                    compare_field("out_tag", want.tag, got.tag);
                    compare_field("out_level", want.lvl, got.lvl);
                    compare_field("total_count", want.total, got.total);
                    compare_field("last", want.last, got.last);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_request(offered_req);
                accepted_items++;
            end
        end
    end

    // driver: present the next pending request once the current one is taken
    always @(negedge i_clk) begin : driver_proc
        pq_req_t nxt;
        if (i_rst_n && !(i_s_axis_tvalid && accepted_items != offered_items)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && expected_results.size() != 0)) begin
                nxt = pending_reqs.pop_front();
                offered_req = nxt;
                i_s_axis_tdata  <= {{(S_TDATA_W-25){1'b0}}, nxt.cnt, nxt.lvl, nxt.tag};
                i_s_axis_tuser  <= nxt.req;
                i_s_axis_tvalid <= 1'b1;
                offered_items++;
                if (accepted_items < calm_from && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 4);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: one long hold-off, short random stalls, none near the end
    always @(negedge i_clk) begin : receiver_proc
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!hold_done && accepted_items >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (accepted_items < calm_from && $urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(1, 4);
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : main_proc
        int r;
        int lvl;
        int burst_lvl;
        bit burst_done;
        bit drain_done;
        burst_done = 1'b0;
        drain_done = 1'b0;

        // directed: empty queue, zero pop, bad levels, full level, oversized and partial pops
        add_req(REQ_POP, 16'hffff, 15, 1);
        add_req(REQ_POP, 0, 0, 0);
        add_req(REQ_INSERT, 16'hffff, 0, 31);
        add_req(REQ_INSERT, 0, 15, 0);
        for (int i = 0; i < LEVEL_DEPTH + 1; i++)
            add_req(REQ_INSERT, (i % 2) ? 16'hffff : i, NUM_LEVELS, 0);
        add_req(REQ_INSERT, 16'h1234, 1, 0);
        add_req(REQ_POP, 0, 0, 31);
        add_req(REQ_POP, 0, 0, MAX_POP);
        add_req(REQ_POP, 0, 0, 1);

        // random: insert runs and pops, with one fill burst and one drain pause
        while (pending_reqs.size() < 25 + RAND_ITEMS) begin
            if (!burst_done && pending_reqs.size() >= 150) begin
                burst_done = 1'b1;
                burst_lvl = $urandom_range(1, NUM_LEVELS);
                repeat (LEVEL_DEPTH + 2) add_req(REQ_INSERT, $urandom, burst_lvl, $urandom);
            end
            if (!drain_done && pending_reqs.size() >= 210) begin
                drain_done = 1'b1;
                drain_next = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
                if ($urandom_range(0, 99) < 85)
                    lvl = $urandom_range(1, NUM_LEVELS);
                else if ($urandom_range(0, 3) == 0)
                    lvl = 0;
                else
                    lvl = $urandom_range(NUM_LEVELS + 1, 15);
                add_req(REQ_INSERT, $urandom, lvl, $urandom);
            end else if (r < 88) begin
                add_req(REQ_POP, $urandom, $urandom, $urandom_range(1, MAX_POP));
            end else if (r < 94) begin
                add_req(REQ_POP, $urandom, $urandom, 0);
            end else begin
                add_req(REQ_POP, $urandom, $urandom, $urandom_range(MAX_POP + 1, 31));
            end
        end
        total_items = pending_reqs.size();
        calm_from   = total_items - CALM_ITEMS;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_items < total_items) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (err_count == 0)
            $display("multilevel_priority_fifo_tb: clean");
        else
            $display("multilevel_priority_fifo_tb: errors");
        $finish;
    end

    // watchdog
    initial begin : watchdog_proc
        #4000000;
        $display("multilevel_priority_fifo_tb: errors");
        $finish;
    end

endmodule

### files.f
src/mlpq_pkg.sv
src/mlpq_ram.sv
src/mlpq_lowest.sv
src/multilevel_priority_fifo.sv
tb/multilevel_priority_fifo_tb.sv
